@@ rtl/core/zgs_pkg.sv @@
package zgs_pkg;

  localparam int CORR_W    = 16;
  localparam int BELONG_W  = 16;
  localparam int WIN_W     = 10;
  localparam int SEG_W     = 17;
  localparam int SUM_OUT_W = 32;

  localparam logic [WIN_W-1:0] WIN_RESET = 10'd8;

  localparam int MAX_LEN_DEF  = 65536;
  localparam int SUM_BITS_DEF = 32;

  typedef struct packed {
    logic [SEG_W-1:0]     seg_start;
    logic [SEG_W-1:0]     seg_length;
    logic [SUM_OUT_W-1:0] seg_sum;
    logic                 seg_final;
  } seg_t;

endpackage

@@ rtl/core/zgs_if.sv @@
interface zgs_in_if;
  import zgs_pkg::*;

  logic                valid;
  logic                ready;
  logic [CORR_W-1:0]   corr_count;
  logic [BELONG_W-1:0] belong_count;
  logic                last_item;

  modport source (output valid, corr_count, belong_count, last_item, input ready);
  modport sink   (input valid, corr_count, belong_count, last_item, output ready);
endinterface

interface zgs_out_if;
  import zgs_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [SEG_W-1:0]     seg_start;
  logic [SEG_W-1:0]     seg_length;
  logic [SUM_OUT_W-1:0] seg_sum;
  logic                 seg_final;

  modport source (output valid, seg_start, seg_length, seg_sum, seg_final, input ready);
  modport sink   (input valid, seg_start, seg_length, seg_sum, seg_final, output ready);
endinterface

@@ rtl/core/zero_gap_segment_splitter.sv @@
// zero gap segment splitter
//
// in_ch carries one sequence position per item: its correlated-group count,
// its own-group count and a flag on the final position. out_ch carries
// segments: start position, length without trailing zero positions, the
// saturating sum of own-group counts and a flag on the sequence's last one.
// cfg_we/cfg_wdata write the window size (reset value 8); write it only
// while no items are in flight.
//
// An item is processed in the cycle it is accepted and its results are
// registered in a four-entry result queue that feeds out_ch. One item is
// taken per cycle while the queue has room for two results; an item that
// both closes a segment and ends the sequence yields two results, which
// leave the queue one after the other. When the receiver stalls the queue
// fills and in_ch.ready drops once fewer than two slots are free.
//
// After reset the queue is empty, the window is 8 and the block waits for
// the first position of a sequence; it waits for a new first position
// again after every item flagged last.
module zero_gap_segment_splitter #(
  parameter int MAX_LEN  = zgs_pkg::MAX_LEN_DEF,
  parameter int SUM_BITS = zgs_pkg::SUM_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [zgs_pkg::WIN_W-1:0] cfg_wdata,
  zgs_in_if.sink                   in_ch,
  zgs_out_if.source                out_ch
);
  import zgs_pkg::*;

  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int CMP_W   = (CNT_W > WIN_W + 1) ? CNT_W : WIN_W + 1;
  localparam int DEPTH   = 4;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int FILL_W  = $clog2(DEPTH + 1);

  localparam logic [CNT_W-1:0]    CNT_MAX = CNT_W'(MAX_LEN);
  localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v >= CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
  endfunction

  logic [WIN_W-1:0]    win_r;
  logic [CNT_W-1:0]    pos_r, pos_nxt;
  logic [CNT_W-1:0]    zrun_r, zrun_nxt;
  logic [CNT_W-1:0]    rlen_r, rlen_nxt;
  logic [SUM_BITS-1:0] rsum_r, rsum_nxt;
  logic                lead_r, lead_nxt;

  seg_t              fifo_mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [FILL_W-1:0] fill_r;

  logic in_fire, pop, nz, split, last;
  logic [CNT_W-1:0]    rlen_a, pos_u, zrun_u, rlen_u;
  logic [SUM_BITS-1:0] rsum_a, rsum_u;
  logic [SUM_BITS:0]   sum_wide;
  seg_t seg_split, seg_last;

  assign in_ch.ready = (fill_r <= FILL_W'(DEPTH - 2));
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign pop         = out_ch.valid && out_ch.ready;
  assign nz          = (in_ch.corr_count != '0);
  assign last        = in_ch.last_item;
  assign split       = nz && (CMP_W'(zrun_r) >= CMP_W'({win_r, 1'b0}));

  always_comb begin
    rlen_a   = split ? '0 : rlen_r;
    rsum_a   = split ? '0 : rsum_r;
    sum_wide = {1'b0, rsum_a} + (SUM_BITS + 1)'(in_ch.belong_count);
    pos_u    = sat_inc(pos_r);
    zrun_u   = zrun_r;
    rlen_u   = rlen_r;
    rsum_u   = rsum_r;
    if (nz) begin
      zrun_u = '0;
      rlen_u = sat_inc(rlen_a);
      rsum_u = (sum_wide > {1'b0, SUM_MAX}) ? SUM_MAX : sum_wide[SUM_BITS-1:0];
    end else if (!lead_r) begin
      zrun_u = sat_inc(zrun_r);
      rlen_u = sat_inc(rlen_r);
    end

    seg_split.seg_start  = SEG_W'(pos_r - rlen_r);
    seg_split.seg_length = SEG_W'(rlen_r - zrun_r);
    seg_split.seg_sum    = SUM_OUT_W'(rsum_r);
    seg_split.seg_final  = 1'b0;

    seg_last.seg_start  = SEG_W'(pos_u - rlen_u);
    seg_last.seg_length = SEG_W'(rlen_u - zrun_u);
    seg_last.seg_sum    = SUM_OUT_W'(rsum_u);
    seg_last.seg_final  = 1'b1;

    if (last) begin
      pos_nxt  = '0;
      zrun_nxt = '0;
      rlen_nxt = '0;
      rsum_nxt = '0;
      lead_nxt = 1'b1;
    end else begin
      pos_nxt  = pos_u;
      zrun_nxt = zrun_u;
      rlen_nxt = rlen_u;
      rsum_nxt = rsum_u;
      lead_nxt = lead_r && !nz;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= WIN_RESET;
      pos_r  <= '0;
      zrun_r <= '0;
      rlen_r <= '0;
      rsum_r <= '0;
      lead_r <= 1'b1;
    end else begin
      if (cfg_we) begin
        win_r <= cfg_wdata;
      end
      if (in_fire) begin
        pos_r  <= pos_nxt;
        zrun_r <= zrun_nxt;
        rlen_r <= rlen_nxt;
        rsum_r <= rsum_nxt;
        lead_r <= lead_nxt;
      end
    end
  end

  // result queue
  logic [1:0]       push_cnt;
  logic [PTR_W-1:0] last_slot;

  assign push_cnt  = in_fire ? (2'(split) + 2'(last)) : 2'd0;
  assign last_slot = wr_ptr_r + PTR_W'(split);

  always_ff @(posedge clk) begin
    if (in_fire && split) begin
      fifo_mem[wr_ptr_r] <= seg_split;
    end
    if (in_fire && last) begin
      fifo_mem[last_slot] <= seg_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(push_cnt);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      fill_r <= fill_r + FILL_W'(push_cnt) - FILL_W'(pop);
    end
  end

  assign out_ch.valid      = (fill_r != '0);
  assign out_ch.seg_start  = fifo_mem[rd_ptr_r].seg_start;
  assign out_ch.seg_length = fifo_mem[rd_ptr_r].seg_length;
  assign out_ch.seg_sum    = fifo_mem[rd_ptr_r].seg_sum;
  assign out_ch.seg_final  = fifo_mem[rd_ptr_r].seg_final;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(DEPTH))
    else $error("result queue overfilled");

  a_zrun_le_rlen: assert property (@(posedge clk) disable iff (!rst_n)
    zrun_r <= rlen_r)
    else $error("zero run longer than open segment");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && last |=> pos_r == '0 && rlen_r == '0 && lead_r)
    else $error("state not cleared after final item");

  a_fill_track: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && last && !pop |=>
      fill_r == $past(fill_r) + FILL_W'(1) + FILL_W'($past(split)))
    else $error("final item results not queued");

  a_lead_no_seg: assert property (@(posedge clk) disable iff (!rst_n)
    lead_r |-> rlen_r == '0 && rsum_r == '0)
    else $error("segment open during leading zeros");

endmodule

@@ dv/zgs_tb_pkg.sv @@
package zgs_tb_pkg;
  import zgs_pkg::*;

  class seg_board;
    bit [WIN_W-1:0]     window;
    bit [SEG_W-1:0]     position;
    bit [SEG_W-1:0]     zero_run;
    bit [SEG_W-1:0]     run_length;
    bit [SUM_OUT_W-1:0] running_sum;
    bit                 leading;
    seg_t               expected_q[$];
    int unsigned        fail_count;
    int unsigned        pos_count;
    int unsigned        seg_count;
    int unsigned        split_count;

    function new();
      window = WIN_RESET;
      clear();
    endfunction

    function void clear();
      position    = '0;
      zero_run    = '0;
      run_length  = '0;
      running_sum = '0;
      leading     = 1'b1;
    endfunction

    function bit [SEG_W-1:0] sat_step(bit [SEG_W-1:0] v);
      return (v >= SEG_W'(MAX_LEN_DEF)) ? SEG_W'(MAX_LEN_DEF) : v + 1'b1;
    endfunction

    function void push_segment(bit fin);
      seg_t s;
      s.seg_start  = position - run_length;
      s.seg_length = run_length - zero_run;
      s.seg_sum    = running_sum;
      s.seg_final  = fin;
      expected_q   = {expected_q, s};
    endfunction

    function void note_position(logic [CORR_W-1:0] corr, logic [BELONG_W-1:0] belong,
                                logic last);
      bit [SUM_OUT_W:0] wide;
      pos_count++;
      if (corr == '0) begin
        if (!leading) begin
          zero_run   = sat_step(zero_run);
          run_length = sat_step(run_length);
        end
      end else begin
        leading = 1'b0;
        if (int'(zero_run) >= 2 * int'(window)) begin
          push_segment(1'b0);
          running_sum = '0;
          run_length  = '0;
        end
        zero_run    = '0;
        wide        = {1'b0, running_sum} + belong;
        running_sum = wide[SUM_OUT_W] ? '1 : wide[SUM_OUT_W-1:0];
        run_length  = sat_step(run_length);
      end
      position = sat_step(position);
      if (last) begin
        push_segment(1'b1);
        clear();
      end
    endfunction

    function void check_segment(seg_t got);
      seg_t want;
      if (expected_q.size() == 0) begin
        $error("segment with nothing pending: start %0d length %0d sum %0d final %0d",
               got.seg_start, got.seg_length, got.seg_sum, got.seg_final);
        fail_count++;
        return;
      end
      want = expected_q.pop_front();
      seg_count++;
      if (!want.seg_final) split_count++;
      if (got.seg_start !== want.seg_start) begin
        $error("seg_start: expected %0d, got %0d", want.seg_start, got.seg_start);
        fail_count++;
      end
      if (got.seg_length !== want.seg_length) begin
        $error("seg_length: expected %0d, got %0d", want.seg_length, got.seg_length);
        fail_count++;
      end
      if (got.seg_sum !== want.seg_sum) begin
        $error("seg_sum: expected %0d, got %0d", want.seg_sum, got.seg_sum);
        fail_count++;
      end
      if (got.seg_final !== want.seg_final) begin
        $error("seg_final: expected %0d, got %0d", want.seg_final, got.seg_final);
        fail_count++;
      end
    endfunction
  endclass

endpackage

@@ dv/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import zgs_pkg::*;
  import zgs_tb_pkg::*;

  localparam int unsigned LIMIT = 2_000_000;

  typedef struct {
    logic [CORR_W-1:0]   corr;
    logic [BELONG_W-1:0] belong;
    logic                last;
  } pos_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [WIN_W-1:0] cfg_wdata;
  logic             rx_ready = 1'b0;

  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          cur_window = int'(WIN_RESET);
  int unsigned cycle_count = 0;
  int unsigned seq_count = 0;
  int unsigned sent_count = 0;
  pos_t        seq_q[$];
  seg_board    sb;

  zgs_in_if  in_ch ();
  zgs_out_if out_ch ();

  zero_gap_segment_splitter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  assign out_ch.ready = rx_ready;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    rx_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    seg_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_position(in_ch.corr_count, in_ch.belong_count, in_ch.last_item);
      if (out_ch.valid && out_ch.ready) begin
        got.seg_start  = out_ch.seg_start;
        got.seg_length = out_ch.seg_length;
        got.seg_sum    = out_ch.seg_sum;
        got.seg_final  = out_ch.seg_final;
        sb.check_segment(got);
      end
    end
  end

  function automatic logic [CORR_W-1:0] pick_corr();
    case ($urandom_range(7))
      0: return 16'h0001;
      1: return 16'hFFFF;
      default: return CORR_W'($urandom_range(1, 65535));
    endcase
  endfunction

  function automatic logic [BELONG_W-1:0] pick_belong();
    case ($urandom_range(7))
      0: return '0;
      1: return 16'hFFFF;
      default: return BELONG_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // zero gaps around the split threshold, mostly short for wide windows
  function automatic int gap_len(int w2);
    if (w2 > 100 && $urandom_range(7) != 0) return $urandom_range(0, 20);
    case ($urandom_range(5))
      0: return 0;
      1: return (w2 > 0) ? w2 - 1 : 0;
      2: return w2;
      3: return w2 + 1;
      4: return $urandom_range(0, 3);
      default: return $urandom_range(0, w2 + 3);
    endcase
  endfunction

  task automatic send_item(logic [CORR_W-1:0] corr, logic [BELONG_W-1:0] belong, logic last);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.corr_count   <= corr;
    in_ch.belong_count <= belong;
    in_ch.last_item    <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic hold_off();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_window(int w);
    hold_off();
    cfg_we    <= 1'b1;
    cfg_wdata <= WIN_W'(w);
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.window  = WIN_W'(w);
    cur_window = w;
  endtask

  task automatic push_pos(logic [CORR_W-1:0] corr);
    pos_t p;
    p.corr   = corr;
    p.belong = pick_belong();
    p.last   = 1'b0;
    seq_q    = {seq_q, p};
  endtask

  task automatic add_zeros(int n);
    repeat (n) push_pos('0);
  endtask

  task automatic build_sequence();
    int w2;
    int n_seg;
    seq_q.delete();
    w2 = 2 * cur_window;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 12)) push_pos($urandom_range(1) ? pick_corr() : '0);
    end else begin
      case ($urandom_range(9))
        0, 1, 2, 3: add_zeros($urandom_range(1, 4));
        4: add_zeros(gap_len(w2));
        default: ;
      endcase
      n_seg = $urandom_range(1, 4);
      for (int s = 0; s < n_seg; s++) begin
        if (s > 0) add_zeros(gap_len(w2));
        repeat ($urandom_range(1, 5)) push_pos(pick_corr());
      end
      case ($urandom_range(9))
        0, 1, 2: add_zeros($urandom_range(1, 3));
        3, 4: add_zeros(gap_len(w2));
        default: ;
      endcase
    end
    seq_q[$].last = 1'b1;
  endtask

  task automatic run_phase(int w, int idle, int stall, int budget);
    int unsigned target;
    set_window(w);
    send_idle_pct = idle;
    stall_pct     = stall;
    target        = sent_count + budget;
    while (sent_count < target) begin
      build_sequence();
      foreach (seq_q[i]) send_item(seq_q[i].corr, seq_q[i].belong, seq_q[i].last);
      seq_count++;
    end
  endtask

  task automatic send_directed();
    // all-zero sequence
    send_item('0, 16'hFFFF, 1'b0);
    send_item('0, 16'h0001, 1'b1);
    // single position
    send_item(16'hFFFF, 16'hFFFF, 1'b1);
    // leading and trailing zeros
    send_item('0, 16'h00AA, 1'b0);
    send_item(16'h0001, 16'h0007, 1'b0);
    send_item('0, 16'h5555, 1'b1);
    // split and final on the same item
    send_item(16'h0001, 16'h8000, 1'b0);
    repeat (16) send_item('0, 16'hFFFF, 1'b0);
    send_item(16'hFFFF, 16'h7FFF, 1'b1);
    seq_count += 4;
  endtask

  initial begin
    sb = new();
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.corr_count   <= '0;
    in_ch.belong_count <= '0;
    in_ch.last_item    <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_directed();
    run_phase(0, 0, 0, 300);
    run_phase(1, 83, 0, 250);
    run_phase(1023, 11, 11, 150);
    run_phase(2, 0, 83, 300);
    run_phase($urandom_range(3, 40), 11, 11, 300);
    run_phase(5, 0, 0, 200);

    hold_off();
    repeat (8) @(posedge clk);
    if (sb.expected_q.size() != 0) begin
      $error("%0d expected segments never arrived", sb.expected_q.size());
      sb.fail_count += sb.expected_q.size();
    end
    $display("run covered %0d positions in %0d sequences over window sizes 0 to 1023",
             sb.pos_count, seq_count);
    $display("%0d segments checked, %0d closed by a zero gap, under sender gaps and stalls",
             sb.seg_count, sb.split_count);
    if (sb.fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
